### src/lrupr_pkg.sv
package lrupr_pkg;

	// Built frame count and the widths that follow from it
	localparam int FRAMES  = 16;
	localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W   = $clog2(FRAMES + 1);

	// Fixed field widths
	localparam int PAGE_W  = 8;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 4;
	localparam int FC_W    = 5;
	localparam int ENTRY_W = PAGE_W + STAMP_W;
	localparam int OUT_W   = 48;

	localparam logic [FC_W-1:0] FC_RESET = FC_W'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	// One result on its way from the controller to the output register
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               replaced;
		logic [PAGE_W-1:0]  evicted_page;
		logic [STAMP_W-1:0] fault_total;
	} result_t;

	// Clamp the configured frame count to 1..FRAMES
	function automatic logic [CNT_W-1:0] frame_limit(input logic [FC_W-1:0] fc);
		int v;
		v = int'(fc);
		if (v == 0) v = 1;
		if (v > FRAMES) v = FRAMES;
		return CNT_W'(v);
	endfunction

	// Low bits of a frame index as the reported slot
	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [31:0] w;
		w = 32'(idx);
		return w[SLOT_W-1:0];
	endfunction

endpackage

### src/lrupr_ram.sv
module lrupr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                              wr_data,
	input  logic                                          rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/lrupr_ctrl.sv
module lrupr_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lrupr_pkg::CNT_W-1:0]   limit,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lrupr_pkg::PAGE_W-1:0]  in_page,
	output logic                          res_valid,
	input  logic                          res_ready,
	output lrupr_pkg::result_t            res
);

	import lrupr_pkg::*;

	state_t               state_q, state_d;
	logic [PAGE_W-1:0]    page_q;
	logic [STAMP_W-1:0]   ref_q;
	logic [STAMP_W-1:0]   fault_q;
	logic [CNT_W-1:0]     filled_q;
	logic [CNT_W-1:0]     issue_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [IDX_W-1:0]     min_idx_q;
	logic [STAMP_W-1:0]   min_stamp_q;
	logic [PAGE_W-1:0]    min_page_q;

	logic                 accept;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic [ENTRY_W-1:0]   rd_data;
	logic [PAGE_W-1:0]    rd_page;
	logic [STAMP_W-1:0]   rd_stamp;
	logic                 wr_en;
	logic                 fill;
	logic [IDX_W-1:0]     dec_idx;
	logic [STAMP_W-1:0]   fault_next;

	// Frame table: page in the upper byte, last-use stamp below
	lrupr_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (FRAMES)
	) u_frames (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (dec_idx),
		.wr_data ({page_q, ref_q}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_page  = rd_data[ENTRY_W-1:STAMP_W];
	assign rd_stamp = rd_data[STAMP_W-1:0];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign rd_en    = (state_q == ST_SCAN) && (issue_q != filled_q);
	assign rd_addr  = issue_q[IDX_W-1:0];

	// Decide between hit, fill and replacement
	assign fill       = !found_q && (filled_q < limit);
	assign dec_idx    = found_q ? hit_idx_q : (fill ? filled_q[IDX_W-1:0] : min_idx_q);
	assign fault_next = found_q ? fault_q :
		((fault_q == '1) ? fault_q : fault_q + STAMP_W'(1));
	assign wr_en      = (state_q == ST_DECIDE) && res_ready;

	assign res_valid        = (state_q == ST_DECIDE);
	assign res.hit          = found_q;
	assign res.slot         = to_slot(dec_idx);
	assign res.replaced     = !found_q && !fill;
	assign res.evicted_page = (!found_q && !fill) ? min_page_q : '0;
	assign res.fault_total  = fault_next;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!rd_en && !vld_s1) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ref_q    <= '0;
			fault_q  <= '0;
			filled_q <= '0;
			issue_q  <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (accept) begin
				ref_q   <= (ref_q == '1) ? ref_q : ref_q + STAMP_W'(1);
				issue_q <= '0;
				found_q <= 1'b0;
			end
			if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			// Keep the first match only
			if (vld_s1 && !found_q && (rd_page == page_q)) begin
				found_q <= 1'b1;
			end
			if (wr_en) begin
				fault_q <= fault_next;
				if (fill) filled_q <= filled_q + CNT_W'(1);
			end
		end
	end

	// Scan payload: page, match index and running minimum
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= in_page;
		end
		idx_s1 <= rd_addr;
		if (vld_s1) begin
			if (!found_q && (rd_page == page_q)) begin
				hit_idx_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (rd_stamp < min_stamp_q)) begin
				min_idx_q   <= idx_s1;
				min_stamp_q <= rd_stamp;
				min_page_q  <= rd_page;
			end
		end
	end

endmodule

### src/lru_page_replacement.sv
// LRU page replacement: each page reference on the input stream yields one
// result with hit/fault, the frame slot used, the evicted page on a
// replacement and the saturating fault total. The frame table sits in one
// synchronous RAM with a single read port and is scanned one frame per cycle,
// over the filled frames only. A result waits in the output register while the
// next reference is taken. frame_count is written through cfg_wen/cfg_wdata
// between references, a rule the user must keep since the block does not
// enforce it; 0 acts as 1 and values above 16 act as 16. Lowering it below
// the current fill keeps the frames already filled.
module lru_page_replacement (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [lrupr_pkg::FC_W-1:0]   cfg_wdata,    // frame_count
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata, // [7:0] page
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [0] hit, [4:1] slot, [5] replaced, [13:6] evicted_page,
	// [45:14] fault_total, [47:46] zero
	output logic [lrupr_pkg::OUT_W-1:0]  m_axis_tdata
);

	import lrupr_pkg::*;

	logic [FC_W-1:0] frame_count_q;
	logic            res_valid;
	logic            res_ready;
	result_t         res;
	result_t         out_q;
	logic            out_valid_q;

	// Hold the frame count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FC_RESET;
		end else if (cfg_wen) begin
			frame_count_q <= cfg_wdata;
		end
	end

	lrupr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (frame_limit(frame_count_q)),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_page   (s_axis_tdata[PAGE_W-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.fault_total, out_q.evicted_page,
		out_q.replaced, out_q.slot, out_q.hit};

endmodule
